>>> rtl/rmp_pkg.sv
// shared types, constants and codes for the registration message parser
package rmp_pkg;

    localparam int unsigned NAME_BUFFER_SIZE = 32;
    localparam int unsigned DUMP_LIMIT       = 64;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned QUEUE_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  HDR_EXT_BIT      = 8'h80;
    localparam logic [7:0]  HDR_ACK_BIT      = 8'h40;
    localparam logic [6:0]  EVENT_MASK       = 7'h60;
    localparam logic [6:0]  EVENT_INITIAL    = 7'h20;
    localparam logic [6:0]  EVENT_REFRESH    = 7'h40;
    localparam logic [7:0]  PRINT_LOW        = 8'h20;
    localparam logic [7:0]  PRINT_END        = 8'h7f;
    localparam logic [11:0] MINUTES_PER_UNIT = 12'd30;

    typedef enum logic [3:0] {
        TYPE_DEVREG     = 4'h0,
        TYPE_DEREG      = 4'h1,
        TYPE_QUERY      = 4'h4,
        TYPE_USERREG    = 4'h5,
        TYPE_USERDEREG  = 4'h6,
        TYPE_USERACK    = 4'h7,
        TYPE_ACK        = 4'hf
    } t_msg_type;

    typedef enum logic [2:0] {
        OUT_DEVREG    = 3'd0,
        OUT_USERREG   = 3'd1,
        OUT_DEREG     = 3'd2,
        OUT_USERDEREG = 3'd3,
        OUT_QUERY     = 3'd4,
        OUT_ACK       = 3'd5,
        OUT_USERACK   = 3'd6,
        OUT_RAW       = 3'd7
    } t_outcome;

    typedef enum logic [2:0] {
        FAIL_OK           = 3'd0,
        FAIL_USER_INVALID = 3'd1,
        FAIL_USER_TIMEOUT = 3'd2,
        FAIL_TX           = 3'd3,
        FAIL_DEV_UNAUTH   = 3'd4,
        FAIL_OTHER        = 3'd5
    } t_fail;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_INITIAL = 2'd1,
        EVT_REFRESH = 2'd2
    } t_event;

    typedef struct packed {
        logic [7:0]  hdr;
        logic        have_ext;
        logic [6:0]  value;
        logic        dev_found;
        logic [15:0] dev_offset;
        logic [4:0]  dev_length;
        logic        usr_found;
        logic [15:0] usr_offset;
        logic [4:0]  usr_length;
        logic        pw_found;
        logic [15:0] rec_length;
    } t_summary;

endpackage

>>> rtl/rmp_front.sv
// front end: per-word header and name field walk, summary on the last word
module rmp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_push,
    output rmp_pkg::t_summary   o_summary
);

    localparam logic [1:0]  FIELD_DEVICE = 2'd0;
    localparam logic [1:0]  FIELD_USER   = 2'd1;
    localparam logic [1:0]  FIELD_DONE   = 2'd3;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;

    logic [15:0] r_count, n_count;
    logic [15:0] r_prefix, n_prefix;
    logic [7:0]  r_hdr1, n_hdr1;
    logic [7:0]  r_hdr2, n_hdr2;
    logic        r_hdr2_seen, n_hdr2_seen;
    logic        r_chain_open, n_chain_open;
    logic [1:0]  r_field_idx, n_field_idx;
    logic [7:0]  r_field_rem, n_field_rem;
    logic [15:0] r_field_start, n_field_start;
    logic        r_field_print, n_field_print;
    logic        r_field_fits, n_field_fits;
    logic        r_dev_found, n_dev_found;
    logic        r_usr_found, n_usr_found;
    logic        r_pw_found, n_pw_found;
    logic [15:0] r_dev_offset, n_dev_offset;
    logic [4:0]  r_dev_length, n_dev_length;
    logic [15:0] r_usr_offset, n_usr_offset;
    logic [4:0]  r_usr_length, n_usr_length;

    logic [15:0] rec_idx;
    logic        in_record;
    logic        printable;
    logic        field_print;
    logic [15:0] total_m2;
    logic [15:0] rec_length;
    logic        have_ext;

    assign rec_idx   = r_count - 16'd2;
    assign in_record = rec_idx < r_prefix;
    assign printable = (i_byte >= rmp_pkg::PRINT_LOW) && (i_byte < rmp_pkg::PRINT_END);

    always_comb begin
        n_count       = r_count;
        n_prefix      = r_prefix;
        n_hdr1        = r_hdr1;
        n_hdr2        = r_hdr2;
        n_hdr2_seen   = r_hdr2_seen;
        n_chain_open  = r_chain_open;
        n_field_idx   = r_field_idx;
        n_field_rem   = r_field_rem;
        n_field_start = r_field_start;
        n_field_print = r_field_print;
        n_field_fits  = r_field_fits;
        n_dev_found   = r_dev_found;
        n_usr_found   = r_usr_found;
        n_pw_found    = r_pw_found;
        n_dev_offset  = r_dev_offset;
        n_dev_length  = r_dev_length;
        n_usr_offset  = r_usr_offset;
        n_usr_length  = r_usr_length;
        field_print   = r_field_print & printable;

        if (i_accept && (r_count != COUNT_MAX)) begin
            n_count = r_count + 16'd1;
            if (r_count == 16'd0) begin
                n_prefix = {i_byte, 8'h00};
            end else if (r_count == 16'd1) begin
                n_prefix = {r_prefix[15:8], i_byte};
            end else if (in_record) begin
                if (rec_idx == 16'd0) begin
                    n_hdr1 = i_byte;
                end
                if (rec_idx == 16'd1) begin
                    n_hdr2      = i_byte;
                    n_hdr2_seen = 1'b1;
                end
                if (r_chain_open) begin
                    if ((i_byte & rmp_pkg::HDR_EXT_BIT) == 8'h00) begin
                        n_chain_open = 1'b0;
                    end
                end else if (r_field_idx != FIELD_DONE) begin
                    if (r_field_rem == 8'd0) begin
                        if (i_byte == 8'd0) begin
                            n_field_idx = r_field_idx + 2'd1;
                        end else begin
                            n_field_rem   = i_byte;
                            n_field_start = rec_idx + 16'd1;
                            n_field_print = 1'b1;
                            n_field_fits  = {1'b0, i_byte} < 9'(rmp_pkg::NAME_BUFFER_SIZE);
                        end
                    end else begin
                        n_field_print = field_print;
                        n_field_rem   = r_field_rem - 8'd1;
                        if (r_field_rem == 8'd1) begin
                            n_field_idx = r_field_idx + 2'd1;
                            if (field_print && r_field_fits) begin
                                case (r_field_idx)
                                    FIELD_DEVICE: begin
                                        n_dev_found  = 1'b1;
                                        n_dev_offset = r_field_start;
                                        n_dev_length = i_byte == i_byte ?
                                                       (rec_idx[4:0] + 5'd1 - r_field_start[4:0]) :
                                                       5'd0;
                                    end
                                    FIELD_USER: begin
                                        n_usr_found  = 1'b1;
                                        n_usr_offset = r_field_start;
                                        n_usr_length = rec_idx[4:0] + 5'd1 - r_field_start[4:0];
                                    end
                                    default: begin
                                        n_pw_found = 1'b1;
                                    end
                                endcase
                            end
                        end
                    end
                end
            end
        end

        total_m2   = n_count - 16'd2;
        rec_length = (n_prefix > total_m2) ? total_m2 : n_prefix;
        have_ext   = ((n_hdr1 & rmp_pkg::HDR_EXT_BIT) != 8'h00) && n_hdr2_seen;

        o_summary.hdr        = n_hdr1;
        o_summary.have_ext   = have_ext;
        o_summary.value      = have_ext ? n_hdr2[6:0] : 7'd0;
        o_summary.dev_found  = n_dev_found;
        o_summary.dev_offset = n_dev_offset;
        o_summary.dev_length = n_dev_length;
        o_summary.usr_found  = n_usr_found;
        o_summary.usr_offset = n_usr_offset;
        o_summary.usr_length = n_usr_length;
        o_summary.pw_found   = n_pw_found;
        o_summary.rec_length = rec_length;

        o_push = 1'b0;
        if (i_accept && i_last) begin
            o_push        = (n_count >= 16'd3) && (rec_length != 16'd0);
            n_count       = 16'd0;
            n_prefix      = 16'd0;
            n_hdr1        = 8'd0;
            n_hdr2        = 8'd0;
            n_hdr2_seen   = 1'b0;
            n_chain_open  = 1'b1;
            n_field_idx   = FIELD_DEVICE;
            n_field_rem   = 8'd0;
            n_field_start = 16'd0;
            n_field_print = 1'b1;
            n_dev_found   = 1'b0;
            n_usr_found   = 1'b0;
            n_pw_found    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= 16'd0;
            r_prefix      <= 16'd0;
            r_hdr1        <= 8'd0;
            r_hdr2        <= 8'd0;
            r_hdr2_seen   <= 1'b0;
            r_chain_open  <= 1'b1;
            r_field_idx   <= FIELD_DEVICE;
            r_field_rem   <= 8'd0;
            r_field_start <= 16'd0;
            r_field_print <= 1'b1;
            r_dev_found   <= 1'b0;
            r_usr_found   <= 1'b0;
            r_pw_found    <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_prefix      <= n_prefix;
            r_hdr1        <= n_hdr1;
            r_hdr2        <= n_hdr2;
            r_hdr2_seen   <= n_hdr2_seen;
            r_chain_open  <= n_chain_open;
            r_field_idx   <= n_field_idx;
            r_field_rem   <= n_field_rem;
            r_field_start <= n_field_start;
            r_field_print <= n_field_print;
            r_dev_found   <= n_dev_found;
            r_usr_found   <= n_usr_found;
            r_pw_found    <= n_pw_found;
        end
    end

    // id payload, only read behind its found flag, and the field fit flag
    always_ff @(posedge i_clk) begin
        r_field_fits <= n_field_fits;
        r_dev_offset <= n_dev_offset;
        r_dev_length <= n_dev_length;
        r_usr_offset <= n_usr_offset;
        r_usr_length <= n_usr_length;
    end

endmodule

>>> rtl/rmp_fifo.sv
// short queue of message summaries between front and back end
module rmp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rmp_pkg::t_summary   i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output rmp_pkg::t_summary   o_data
);

    localparam logic [rmp_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        rmp_pkg::QUEUE_PTR_W'(rmp_pkg::QUEUE_DEPTH - 1);
    localparam logic [rmp_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        rmp_pkg::QUEUE_CNT_W'(rmp_pkg::QUEUE_DEPTH);

    rmp_pkg::t_summary r_mem [rmp_pkg::QUEUE_DEPTH];
    logic [rmp_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rmp_pkg::QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [rmp_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CNT_FULL;
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("summary queue count beyond depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("summary queue lost a push");
`endif

endmodule

>>> rtl/rmp_back.sv
// back end: message classification and result register
module rmp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sum_empty,
    input  rmp_pkg::t_summary   i_sum,
    output logic                o_sum_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [2:0]          o_outcome,
    output logic [2:0]          o_fail_reason,
    output logic [6:0]          o_timer_value,
    output logic [11:0]         o_refresh_minutes,
    output logic [1:0]          o_event_kind,
    output logic                o_password_present,
    output logic [15:0]         o_device_offset,
    output logic [4:0]          o_device_length,
    output logic [15:0]         o_user_offset,
    output logic [4:0]          o_user_length,
    output logic [6:0]          o_dump_length,
    output logic [15:0]         o_record_length
);

    logic                r_valid, n_valid;
    rmp_pkg::t_outcome   r_outcome, n_outcome;
    rmp_pkg::t_fail      r_fail, n_fail;
    logic [6:0]          r_timer, n_timer;
    logic [11:0]         r_refresh, n_refresh;
    rmp_pkg::t_event     r_event, n_event;
    logic                r_pw, n_pw;
    logic [15:0]         r_dev_offset, n_dev_offset;
    logic [4:0]          r_dev_length, n_dev_length;
    logic [15:0]         r_usr_offset, n_usr_offset;
    logic [4:0]          r_usr_length, n_usr_length;
    logic [6:0]          r_dump, n_dump;
    logic [15:0]         r_rec_length, n_rec_length;

    logic [3:0]          msg_type;
    logic                has_ack;
    logic [15:0]         dump_full;

    assign o_sum_pop = !i_sum_empty && (!r_valid || i_pop);
    assign msg_type  = i_sum.hdr[3:0];
    assign has_ack   = (i_sum.hdr & rmp_pkg::HDR_ACK_BIT) != 8'h00;
    assign dump_full = (i_sum.rec_length > 16'(rmp_pkg::DUMP_LIMIT)) ?
                       16'(rmp_pkg::DUMP_LIMIT) : i_sum.rec_length;

    always_comb begin
        n_outcome    = rmp_pkg::OUT_RAW;
        n_fail       = rmp_pkg::FAIL_OK;
        n_timer      = 7'd0;
        n_refresh    = 12'd0;
        n_event      = rmp_pkg::EVT_NONE;
        n_pw         = 1'b0;
        n_dev_offset = 16'd0;
        n_dev_length = 5'd0;
        n_usr_offset = 16'd0;
        n_usr_length = 5'd0;
        n_rec_length = i_sum.rec_length;

        unique case (msg_type) inside
            rmp_pkg::TYPE_DEVREG, rmp_pkg::TYPE_USERREG: begin
                if (i_sum.dev_found || i_sum.usr_found) begin
                    n_outcome = (msg_type == rmp_pkg::TYPE_USERREG) ?
                                rmp_pkg::OUT_USERREG : rmp_pkg::OUT_DEVREG;
                    if (msg_type == rmp_pkg::TYPE_DEVREG && i_sum.have_ext) begin
                        if ((i_sum.value & rmp_pkg::EVENT_MASK) == rmp_pkg::EVENT_INITIAL) begin
                            n_event = rmp_pkg::EVT_INITIAL;
                        end else if ((i_sum.value & rmp_pkg::EVENT_MASK) ==
                                     rmp_pkg::EVENT_REFRESH) begin
                            n_event = rmp_pkg::EVT_REFRESH;
                        end
                    end
                    n_pw = i_sum.pw_found;
                    if (i_sum.dev_found) begin
                        n_dev_offset = i_sum.dev_offset;
                        n_dev_length = i_sum.dev_length;
                    end
                    if (i_sum.usr_found) begin
                        n_usr_offset = i_sum.usr_offset;
                        n_usr_length = i_sum.usr_length;
                    end
                end
            end
            rmp_pkg::TYPE_DEREG: begin
                n_outcome = rmp_pkg::OUT_DEREG;
            end
            rmp_pkg::TYPE_USERDEREG: begin
                n_outcome = rmp_pkg::OUT_USERDEREG;
            end
            rmp_pkg::TYPE_QUERY: begin
                n_outcome = rmp_pkg::OUT_QUERY;
            end
            rmp_pkg::TYPE_USERACK: begin
                n_outcome = rmp_pkg::OUT_USERACK;
                n_timer   = i_sum.value;
                if (has_ack) begin
                    if (i_sum.value == 7'd1) begin
                        n_fail = rmp_pkg::FAIL_USER_INVALID;
                    end else if (i_sum.value == 7'd2) begin
                        n_fail = rmp_pkg::FAIL_USER_TIMEOUT;
                    end else begin
                        n_fail = rmp_pkg::FAIL_TX;
                    end
                end
            end
            rmp_pkg::TYPE_ACK: begin
                n_outcome = rmp_pkg::OUT_ACK;
                n_timer   = i_sum.value;
                if (has_ack) begin
                    n_fail = (i_sum.value == 7'd0) ? rmp_pkg::FAIL_DEV_UNAUTH :
                                                     rmp_pkg::FAIL_OTHER;
                end else begin
                    n_refresh = 12'(i_sum.value) * rmp_pkg::MINUTES_PER_UNIT;
                end
            end
            default: begin
                n_outcome = rmp_pkg::OUT_RAW;
            end
        endcase

        n_dump = (n_outcome == rmp_pkg::OUT_RAW) ? dump_full[6:0] : 7'd0;

        n_valid = r_valid;
        if (o_sum_pop) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sum_pop) begin
            r_outcome    <= n_outcome;
            r_fail       <= n_fail;
            r_timer      <= n_timer;
            r_refresh    <= n_refresh;
            r_event      <= n_event;
            r_pw         <= n_pw;
            r_dev_offset <= n_dev_offset;
            r_dev_length <= n_dev_length;
            r_usr_offset <= n_usr_offset;
            r_usr_length <= n_usr_length;
            r_dump       <= n_dump;
            r_rec_length <= n_rec_length;
        end
    end

    assign o_empty            = !r_valid;
    assign o_outcome          = r_outcome;
    assign o_fail_reason      = r_fail;
    assign o_timer_value      = r_timer;
    assign o_refresh_minutes  = r_refresh;
    assign o_event_kind       = r_event;
    assign o_password_present = r_pw;
    assign o_device_offset    = r_dev_offset;
    assign o_device_length    = r_dev_length;
    assign o_user_offset      = r_user_offset_unused_guard(r_usr_offset);
    assign o_user_length      = r_usr_length;
    assign o_dump_length      = r_dump;
    assign o_record_length    = r_rec_length;

    function automatic logic [15:0] r_user_offset_unused_guard(input logic [15:0] v);
        return v;
    endfunction

`ifndef SYNTHESIS
    a_rec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_rec_length != 16'd0)
        else $error("result with empty record");

    a_dump_only_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_outcome != rmp_pkg::OUT_RAW |-> r_dump == 7'd0)
        else $error("dump length on a parsed message");

    a_refresh_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_refresh != 12'd0 |->
            r_outcome == rmp_pkg::OUT_ACK && r_fail == rmp_pkg::FAIL_OK)
        else $error("refresh time outside a successful device ack");
`endif

endmodule

>>> rtl/registration_message_parser.sv
// top level of the registration message parser
//
// channel   direction  handshake           payload
// input     in         i_push / o_full     i_msg_byte, i_msg_last
// result    out        o_empty / i_pop     o_outcome .. o_record_length
//
// one word is taken every cycle while o_full is low; the header and field walk
// updates the front end state on each word taken.
// a message ending on i_msg_last gives its result through a two-entry summary
// queue and then the result register.
// o_full is the summary queue's full flag; the queue fills only while the result is not taken.
// i_rst_n is synchronous and active low; no clearing pass is needed after reset.
module registration_message_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_msg_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_outcome,
    output logic [2:0]  o_fail_reason,
    output logic [6:0]  o_timer_value,
    output logic [11:0] o_refresh_minutes,
    output logic [1:0]  o_event_kind,
    output logic        o_password_present,
    output logic [15:0] o_device_offset,
    output logic [4:0]  o_device_length,
    output logic [15:0] o_user_offset,
    output logic [4:0]  o_user_length,
    output logic [6:0]  o_dump_length,
    output logic [15:0] o_record_length
);

    logic              accept;
    logic              sum_push;
    rmp_pkg::t_summary sum_in;
    logic              sum_empty;
    logic              sum_pop;
    rmp_pkg::t_summary sum_out;

    assign accept = i_push && !o_full;

    rmp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_msg_byte),
        .i_last    (i_msg_last),
        .o_push    (sum_push),
        .o_summary (sum_in)
    );

    rmp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_in),
        .o_full  (o_full),
        .i_pop   (sum_pop),
        .o_empty (sum_empty),
        .o_data  (sum_out)
    );

    rmp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_sum_empty        (sum_empty),
        .i_sum              (sum_out),
        .o_sum_pop          (sum_pop),
        .i_pop              (i_pop),
        .o_empty            (o_empty),
        .o_outcome          (o_outcome),
        .o_fail_reason      (o_fail_reason),
        .o_timer_value      (o_timer_value),
        .o_refresh_minutes  (o_refresh_minutes),
        .o_event_kind       (o_event_kind),
        .o_password_present (o_password_present),
        .o_device_offset    (o_device_offset),
        .o_device_length    (o_device_length),
        .o_user_offset      (o_user_offset),
        .o_user_length      (o_user_length),
        .o_dump_length      (o_dump_length),
        .o_record_length    (o_record_length)
    );

endmodule
